// ===== rtl/fbr_pkg.sv =====
package fbr_pkg;

    // Default geometry of the frame store.
    localparam int DEF_WIDTH  = 128;
    localparam int DEF_HEIGHT = 64;

    localparam logic [1:0] MODE_PIXEL    = 2'd0;
    localparam logic [1:0] MODE_BYTE     = 2'd1;
    localparam logic [1:0] MODE_REFRESH  = 2'd2;
    localparam logic [1:0] MODE_CONTRAST = 2'd3;

    // Controller command bytes.
    localparam logic [7:0] CMD_PAGE      = 8'hB0;
    localparam logic [7:0] CMD_PAGE_MASK = 8'h07;
    localparam logic [7:0] CMD_COL_HI    = 8'h10;
    localparam logic [7:0] CMD_COL_LO    = 8'h00;
    localparam logic [7:0] CMD_CONTRAST  = 8'h81;
    localparam logic [7:0] CONTRAST_MASK = 8'h3F;

endpackage

// ===== rtl/page_framebuffer_refresh.sv =====
// Page-organized monochrome frame store (WIDTH columns by HEIGHT rows, one byte per
// column and page of eight rows, bit 0 on top) with a refresh output for a page-mode
// display controller. After reset the block first zeroes the store, one byte per cycle;
// i_valid items are held off by o_stall until that pass completes. Items are then
// handled one at a time around a single memory with a registered read port: a byte
// write goes straight in, a pixel write reads the byte and writes back the modified
// byte, a contrast request sends the command byte and then the contrast value, and a
// refresh tick sends the stored byte, after the three address commands when it opens a
// page. Results leave through one output register, one per cycle while i_stall is low;
// i_stall on the output holds the item until its results are taken.
module page_framebuffer_refresh #(
    parameter int WIDTH  = fbr_pkg::DEF_WIDTH,
    parameter int HEIGHT = fbr_pkg::DEF_HEIGHT
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [1:0] i_mode,
    input  logic [6:0] i_x,
    input  logic [5:0] i_y,
    input  logic       i_pixel_on,
    input  logic [7:0] i_byte_value,
    input  logic       i_reverse,
    input  logic [5:0] i_contrast,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_out_byte,
    output logic       o_is_data,
    output logic       o_last
);

    import fbr_pkg::*;

    localparam int PAGES  = HEIGHT / 8;
    localparam int DEPTH  = WIDTH * PAGES;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int COL_W  = $clog2(WIDTH);
    localparam int PG_W   = (PAGES > 1) ? $clog2(PAGES) : 1;

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_WR    = 2'd2;
    localparam logic [1:0] ST_EMIT  = 2'd3;

    logic [1:0]        r_state, n_state;
    logic [ADDR_W-1:0] r_clr_addr, n_clr_addr;
    logic [ADDR_W-1:0] r_scan_addr, n_scan_addr;
    logic [COL_W-1:0]  r_scan_col, n_scan_col;
    logic [PG_W-1:0]   r_scan_page, n_scan_page;
    logic [ADDR_W-1:0] r_addr, n_addr;
    logic [2:0]        r_bit, n_bit;
    logic              r_set, n_set;
    logic              r_kind_tick, n_kind_tick;
    logic [1:0]        r_step, n_step;
    logic [2:0]        r_page, n_page;
    logic [5:0]        r_contrast, n_contrast;
    logic              r_out_valid, n_out_valid;
    logic [7:0]        r_out_byte, n_out_byte;
    logic              r_is_data, n_is_data;
    logic              r_last, n_last;

    logic              accept;
    logic [2:0]        in_page;
    logic [11:0]       in_addr_full;
    logic [ADDR_W-1:0] in_addr;
    logic              in_range;
    logic              scan_end;
    logic              col_end;

    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [7:0]        mem_wdata;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_raddr;
    logic [7:0]        mem_rdata;
    logic [7:0]        bit_mask;

    logic [7:0]        emit_byte;
    logic              emit_data;
    logic              emit_last;
    logic              out_free;

    fbr_ram #(
        .DATA_W (8),
        .DEPTH  (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign o_stall = (r_state != ST_IDLE);
    assign accept  = i_valid && !o_stall;

    assign in_page      = i_y[5:3];
    assign in_addr_full = 12'(in_page) * 12'(WIDTH) + 12'(i_x);
    assign in_addr      = in_addr_full[ADDR_W-1:0];
    assign in_range     = (9'(i_x) < 9'(WIDTH)) && (4'(in_page) < 4'(PAGES));

    assign scan_end = (r_scan_addr == ADDR_W'(DEPTH - 1));
    assign col_end  = (r_scan_col == COL_W'(WIDTH - 1));
    assign bit_mask = 8'd1 << r_bit;
    assign out_free = !r_out_valid || !i_stall;

    // Memory port selection.
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = in_addr;
        mem_wdata = i_reverse ? ~i_byte_value : i_byte_value;
        mem_re    = 1'b0;
        mem_raddr = r_scan_addr;
        if (r_state == ST_CLEAR) begin
            mem_we    = 1'b1;
            mem_waddr = r_clr_addr;
            mem_wdata = 8'd0;
        end else if (r_state == ST_WR) begin
            mem_we    = 1'b1;
            mem_waddr = r_addr;
            mem_wdata = r_set ? (mem_rdata | bit_mask) : (mem_rdata & ~bit_mask);
        end else if (accept) begin
            if (i_mode == MODE_BYTE) begin
                mem_we = in_range;
            end else if (i_mode == MODE_PIXEL) begin
                mem_re    = in_range;
                mem_raddr = in_addr;
            end else if (i_mode == MODE_REFRESH) begin
                mem_re = 1'b1;
            end
        end
    end

    // Result selection for the current step.
    always_comb begin
        emit_data = 1'b0;
        emit_last = 1'b0;
        emit_byte = CMD_CONTRAST;
        if (r_kind_tick) begin
            case (r_step)
                2'd0:    emit_byte = CMD_PAGE | ({5'd0, r_page} & CMD_PAGE_MASK);
                2'd1:    emit_byte = CMD_COL_HI;
                2'd2:    emit_byte = CMD_COL_LO;
                default: begin
                    emit_byte = mem_rdata;
                    emit_data = 1'b1;
                    emit_last = 1'b1;
                end
            endcase
        end else if (r_step != 2'd0) begin
            emit_byte = {2'd0, r_contrast} & CONTRAST_MASK;
            emit_last = 1'b1;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_clr_addr  = r_clr_addr;
        n_scan_addr = r_scan_addr;
        n_scan_col  = r_scan_col;
        n_scan_page = r_scan_page;
        n_addr      = r_addr;
        n_bit       = r_bit;
        n_set       = r_set;
        n_kind_tick = r_kind_tick;
        n_step      = r_step;
        n_page      = r_page;
        n_contrast  = r_contrast;
        n_out_valid = r_out_valid && i_stall;
        n_out_byte  = r_out_byte;
        n_is_data   = r_is_data;
        n_last      = r_last;
        unique case (r_state)
            ST_CLEAR: begin
                n_clr_addr = r_clr_addr + ADDR_W'(1);
                if (r_clr_addr == ADDR_W'(DEPTH - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    unique case (i_mode)
                        MODE_PIXEL: begin
                            n_addr = in_addr;
                            n_bit  = i_y[2:0];
                            n_set  = i_pixel_on ^ i_reverse;
                            if (in_range) begin
                                n_state = ST_WR;
                            end
                        end
                        MODE_BYTE: begin
                            n_state = ST_IDLE;
                        end
                        MODE_REFRESH: begin
                            n_state     = ST_EMIT;
                            n_kind_tick = 1'b1;
                            n_page      = 3'(r_scan_page);
                            // A page opens with its three address commands.
                            n_step      = (r_scan_col == '0) ? 2'd0 : 2'd3;
                            if (scan_end) begin
                                n_scan_addr = '0;
                                n_scan_col  = '0;
                                n_scan_page = '0;
                            end else begin
                                n_scan_addr = r_scan_addr + ADDR_W'(1);
                                if (col_end) begin
                                    n_scan_col  = '0;
                                    n_scan_page = r_scan_page + PG_W'(1);
                                end else begin
                                    n_scan_col = r_scan_col + COL_W'(1);
                                end
                            end
                        end
                        MODE_CONTRAST: begin
                            n_state     = ST_EMIT;
                            n_kind_tick = 1'b0;
                            n_step      = 2'd0;
                            n_contrast  = i_contrast;
                        end
                        default: n_state = ST_IDLE;
                    endcase
                end
            end
            ST_WR: begin
                n_state = ST_IDLE;
            end
            ST_EMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_byte  = emit_byte;
                    n_is_data   = emit_data;
                    n_last      = emit_last;
                    n_step      = r_step + 2'd1;
                    if (emit_last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_scan_addr <= '0;
            r_scan_col  <= '0;
            r_scan_page <= '0;
            r_kind_tick <= 1'b0;
            r_step      <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_scan_addr <= n_scan_addr;
            r_scan_col  <= n_scan_col;
            r_scan_page <= n_scan_page;
            r_kind_tick <= n_kind_tick;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr     <= n_addr;
        r_bit      <= n_bit;
        r_set      <= n_set;
        r_page     <= n_page;
        r_contrast <= n_contrast;
        r_out_byte <= n_out_byte;
        r_is_data  <= n_is_data;
        r_last     <= n_last;
    end

    assign o_valid    = r_out_valid;
    assign o_out_byte = r_out_byte;
    assign o_is_data  = r_is_data;
    assign o_last     = r_last;

    // The stored byte being sent must not be disturbed by a write while results drain.
    a_no_write_in_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |-> !mem_we)
        else $error("frame store written while results are draining");

    a_scan_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_scan_addr == '0) |-> (r_scan_col == '0 && r_scan_page == '0))
        else $error("scan column or page out of step with scan address");

    a_contrast_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT && !r_kind_tick) |-> (r_step == 2'd0 || r_step == 2'd1))
        else $error("contrast sequence ran past its second byte");

    a_pixel_rmw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WR) |-> $past(mem_re) && $past(r_state == ST_IDLE))
        else $error("pixel write-back without a preceding read");

endmodule

// ===== rtl/fbr_ram.sv =====
module fbr_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [DATA_W-1:0]        i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [DATA_W-1:0]        o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
